// ===== hw/rtl/dwa_pkg.sv =====
// Shared types and constants of the DFA word acceptor.
package dwa_pkg;

    localparam int STATE_W     = 4;
    localparam int SYMBOL_W    = 8;
    localparam int MASK_W      = 16;
    localparam int REQ_W       = 2;

    // s_tdata layout, lowest bit first
    localparam int FROM_LSB    = 0;
    localparam int SYM_LSB     = FROM_LSB + STATE_W;
    localparam int NEXT_LSB    = SYM_LSB + SYMBOL_W;
    localparam int S_TDATA_W   = 16;
    localparam int M_TDATA_W   = 8;

    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_START_STATE = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ACCEPT_MASK = 8'd1;

    // verdict queue
    localparam int VFIFO_DEPTH = 4;
    localparam int VFIFO_PTR_W = 2;
    localparam int VFIFO_CNT_W = 3;

    typedef enum logic [REQ_W-1:0] {
        REQ_LOAD   = 2'd0,
        REQ_SYMBOL = 2'd1,
        REQ_EMPTY  = 2'd2
    } req_t;

    typedef struct packed {
        logic               valid;
        logic [STATE_W-1:0] nxt;
    } entry_t;

    typedef struct packed {
        logic we;
        logic re;
    } mem_cmd_t;

endpackage

// ===== hw/rtl/dwa_trans_mem.sv =====
// Transition store: synchronous single-port memory with a clearing sweep after reset.
module dwa_trans_mem
    import dwa_pkg::*;
#(
    parameter int ADDR_W = 12
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  mem_cmd_t          cmd,
    input  logic [ADDR_W-1:0] addr,
    input  entry_t            wdata,
    output entry_t            rdata,
    output logic              clr_busy
);

    entry_t            mem [2**ADDR_W];
    entry_t            rdata_reg;
    logic              clr_busy_reg;
    logic              clr_busy_next;
    logic [ADDR_W-1:0] clr_addr_reg;
    logic [ADDR_W-1:0] clr_addr_next;

    always_comb begin
        clr_addr_next = clr_addr_reg;
        clr_busy_next = clr_busy_reg;
        if (clr_busy_reg) begin
            clr_addr_next = clr_addr_reg + ADDR_W'(1);
            if (clr_addr_reg == {ADDR_W{1'b1}}) begin
                clr_busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end else begin
            clr_busy_reg <= clr_busy_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    // sweep the store to absent entries, then serve the datapath
    always_ff @(posedge aclk) begin
        if (clr_busy_reg) begin
            mem[clr_addr_reg] <= '0;
        end else if (cmd.we) begin
            mem[addr] <= wdata;
        end
        if (cmd.re) begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata    = rdata_reg;
    assign clr_busy = clr_busy_reg;

    a_single_port : assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.we && cmd.re))
        else $error("transition store read and written in one cycle");

    a_quiet_in_sweep : assert property (@(posedge aclk) disable iff (!aresetn)
        clr_busy_reg |-> !(cmd.we || cmd.re))
        else $error("transition store accessed during clearing sweep");

    a_sweep_complete : assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(clr_busy_reg) |-> ($past(clr_addr_reg) == {ADDR_W{1'b1}}))
        else $error("clearing sweep ended before the last entry");

endmodule

// ===== hw/rtl/dwa_verdict_fifo.sv =====
// Small queue that holds verdict words until the result side takes them.
module dwa_verdict_fifo
    import dwa_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   push,
    input  logic                   push_data,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic                   out_data,
    output logic [VFIFO_CNT_W-1:0] count
);

    logic [VFIFO_DEPTH-1:0] slot_reg;
    logic [VFIFO_PTR_W-1:0] wr_ptr_reg;
    logic [VFIFO_PTR_W-1:0] rd_ptr_reg;
    logic [VFIFO_CNT_W-1:0] count_reg;
    logic [VFIFO_CNT_W-1:0] count_next;
    logic                   pop;

    assign pop       = out_valid && out_ready;
    assign out_valid = (count_reg != '0);
    assign out_data  = slot_reg[rd_ptr_reg];
    assign count     = count_reg;

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + VFIFO_CNT_W'(1);
        end else if (!push && pop) begin
            count_next = count_reg - VFIFO_CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + VFIFO_PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + VFIFO_PTR_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_no_overflow : assert property (@(posedge aclk) disable iff (!aresetn)
        !(push && (count_reg == VFIFO_CNT_W'(VFIFO_DEPTH))))
        else $error("verdict pushed into a full queue");

endmodule

// ===== hw/rtl/dfa_word_acceptor.sv =====
// Top level of the table-driven DFA word acceptor.
// Load words write one transition (from_state, symbol) -> next_state into a transition store
// held in a synchronous memory of 2**(clog2(NUM_STATES)+clog2(NUM_SYMBOLS)) entries; symbol
// words run the automaton one character each from start_state, and the last symbol of a word
// or an empty-word request yields one verdict word on m_tdata[0]. After reset the store is
// swept to absent entries, one entry a cycle; s_tready stays low while the sweep lasts, and
// configuration writes are taken throughout. Afterwards the block takes one word every cycle
// while the verdict queue has room: the loop that sets this is the memory read of one symbol,
// whose registered data selects the address of the next symbol's read in the following cycle.
// A verdict is registered in p_verdict_reg when its word is taken, is pushed from there into
// a four-entry queue and is handed over from that queue; s_tready drops only while that queue
// could overflow. Configuration registers: index 0 start_state, index 1 accept_mask.
module dfa_word_acceptor
    import dwa_pkg::*;
#(
    parameter int NUM_STATES  = 16,
    parameter int NUM_SYMBOLS = 256
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // input words
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [S_TDATA_W-1:0]   s_tdata,   // from_state[3:0], symbol[11:4], next_state[15:12]
    input  logic [REQ_W-1:0]       s_tuser,   // req_type[1:0]
    input  logic                   s_tlast,   // last_symbol
    // verdict words
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [M_TDATA_W-1:0]   m_tdata,   // accepted[0], zeros above
    // configuration writes
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int ST_IDX_W  = $clog2(NUM_STATES);
    localparam int SYM_IDX_W = $clog2(NUM_SYMBOLS);
    localparam int ADDR_W    = ST_IDX_W + SYM_IDX_W;

    // map a state or symbol code onto the index bits of the store address
    function automatic logic [ST_IDX_W-1:0] st_idx(input logic [STATE_W-1:0] st);
        logic [ST_IDX_W+STATE_W-1:0] ext;
        ext = {{ST_IDX_W{1'b0}}, st};
        return ext[ST_IDX_W-1:0];
    endfunction

    function automatic logic [SYM_IDX_W-1:0] sym_idx(input logic [SYMBOL_W-1:0] sym);
        logic [SYM_IDX_W+SYMBOL_W-1:0] ext;
        ext = {{SYM_IDX_W{1'b0}}, sym};
        return ext[SYM_IDX_W-1:0];
    endfunction

    // configuration
    logic [STATE_W-1:0]     start_state_reg;
    logic [MASK_W-1:0]      accept_mask_reg;

    // word context and the lookup stage
    logic [STATE_W-1:0]     state_reg,  state_next;
    logic                   dead_reg,   dead_next;
    logic                   in_word_reg, in_word_next;
    logic                   p_lookup_reg, p_lookup_next;
    logic                   p_verdict_reg, p_verdict_next;
    logic                   p_empty_reg, p_empty_next;
    logic                   p_empty_acc_reg, p_empty_acc_next;

    logic                   s_accept;
    req_t                   req;
    logic [STATE_W-1:0]     in_from;
    logic [SYMBOL_W-1:0]    in_sym;
    logic [STATE_W-1:0]     in_next;
    logic                   from_ok;
    logic                   next_ok;
    logic                   sym_ok;
    logic                   cur_ok;

    logic                   res_dead;
    logic [STATE_W-1:0]     res_state;
    logic                   wb_dead;
    logic [STATE_W-1:0]     wb_state;
    logic                   verdict;

    mem_cmd_t               mem_cmd;
    logic [ADDR_W-1:0]      mem_addr;
    entry_t                 mem_wdata;
    entry_t                 mem_rdata;
    logic                   clr_busy;

    logic [VFIFO_CNT_W-1:0] fifo_count;
    logic                   fifo_room;
    logic                   fifo_out;

    // unpack the input word
    assign req     = req_t'(s_tuser);
    assign in_from = s_tdata[FROM_LSB +: STATE_W];
    assign in_sym  = s_tdata[SYM_LSB +: SYMBOL_W];
    assign in_next = s_tdata[NEXT_LSB +: STATE_W];

    // hold input words while the store is swept or the verdict queue could overflow
    assign fifo_room = ({1'b0, fifo_count} + {{VFIFO_CNT_W{1'b0}}, p_verdict_reg})
                       < (VFIFO_CNT_W+1)'(VFIFO_DEPTH);
    assign s_tready  = !clr_busy && fifo_room;
    assign s_accept  = s_tvalid && s_tready;

    // context as it stands this cycle: a lookup issued last cycle resolves from the read data
    assign res_dead  = p_lookup_reg ? !mem_rdata.valid : dead_reg;
    assign res_state = (p_lookup_reg && mem_rdata.valid) ? mem_rdata.nxt : state_reg;

    // the first symbol of a word starts from start_state, alive
    assign wb_state  = in_word_reg ? res_state : start_state_reg;
    assign wb_dead   = in_word_reg ? res_dead  : 1'b0;

    assign from_ok   = 32'(in_from)  < NUM_STATES;
    assign next_ok   = 32'(in_next)  < NUM_STATES;
    assign sym_ok    = 32'(in_sym)   < NUM_SYMBOLS;
    assign cur_ok    = 32'(wb_state) < NUM_STATES;

    assign mem_wdata = '{valid: 1'b1, nxt: in_next};
    assign mem_addr  = (req == REQ_LOAD) ? {st_idx(in_from),  sym_idx(in_sym)}
                                         : {st_idx(wb_state), sym_idx(in_sym)};

    // verdict of the word that ended last cycle
    assign verdict = p_empty_reg ? p_empty_acc_reg
                                 : (!res_dead && accept_mask_reg[res_state]);

    always_comb begin
        state_next       = res_state;
        dead_next        = res_dead;
        in_word_next     = in_word_reg;
        p_lookup_next    = 1'b0;
        p_verdict_next   = 1'b0;
        p_empty_next     = 1'b0;
        p_empty_acc_next = p_empty_acc_reg;
        mem_cmd          = '0;
        if (s_accept) begin
            case (req)
                REQ_LOAD: begin
                    // drop loads outside the table
                    if (from_ok && next_ok && sym_ok) begin
                        mem_cmd.we = 1'b1;
                    end
                end
                REQ_SYMBOL: begin
                    state_next = wb_state;
                    dead_next  = wb_dead;
                    if (!wb_dead && cur_ok && sym_ok) begin
                        mem_cmd.re    = 1'b1;
                        p_lookup_next = 1'b1;
                    end else begin
                        dead_next = 1'b1;
                    end
                    in_word_next   = !s_tlast;
                    p_verdict_next = s_tlast;
                end
                REQ_EMPTY: begin
                    // abandon any word in progress
                    state_next       = start_state_reg;
                    dead_next        = 1'b0;
                    in_word_next     = 1'b0;
                    p_verdict_next   = 1'b1;
                    p_empty_next     = 1'b1;
                    p_empty_acc_next = accept_mask_reg[start_state_reg];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= '0;
            dead_reg        <= 1'b0;
            in_word_reg     <= 1'b0;
            p_lookup_reg    <= 1'b0;
            p_verdict_reg   <= 1'b0;
            p_empty_reg     <= 1'b0;
            p_empty_acc_reg <= 1'b0;
        end else begin
            state_reg       <= state_next;
            dead_reg        <= dead_next;
            in_word_reg     <= in_word_next;
            p_lookup_reg    <= p_lookup_next;
            p_verdict_reg   <= p_verdict_next;
            p_empty_reg     <= p_empty_next;
            p_empty_acc_reg <= p_empty_acc_next;
        end
    end

    // configuration registers; indices beyond the list are ignored
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_state_reg <= '0;
            accept_mask_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_START_STATE: start_state_reg <= cfg_data[STATE_W-1:0];
                REG_ACCEPT_MASK: accept_mask_reg <= cfg_data[MASK_W-1:0];
                default: begin
                end
            endcase
        end
    end

    dwa_trans_mem #(
        .ADDR_W (ADDR_W)
    ) u_store (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (mem_cmd),
        .addr     (mem_addr),
        .wdata    (mem_wdata),
        .rdata    (mem_rdata),
        .clr_busy (clr_busy)
    );

    dwa_verdict_fifo u_verdicts (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (p_verdict_reg),
        .push_data (verdict),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (fifo_out),
        .count     (fifo_count)
    );

    assign m_tdata = {{(M_TDATA_W-1){1'b0}}, fifo_out};

    a_hold_in_sweep : assert property (@(posedge aclk) disable iff (!aresetn)
        clr_busy |-> !s_accept)
        else $error("input word taken during clearing sweep");

    a_lookup_live_word : assert property (@(posedge aclk) disable iff (!aresetn)
        p_lookup_reg |-> !dead_reg)
        else $error("lookup issued for a dead word");

    a_empty_gives_verdict : assert property (@(posedge aclk) disable iff (!aresetn)
        p_empty_reg |-> (p_verdict_reg && !p_lookup_reg))
        else $error("empty-word verdict lost or mixed with a lookup");

endmodule
